/* rtl/core/gdmc_pkg.sv */
package gdmc_pkg;

	localparam int OP_W       = 4;
	localparam int DIST_W     = 16;
	localparam int TIMEOUT_W  = 24;
	localparam int BACKOFF_W  = 16;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;

	localparam logic [TIMEOUT_W-1:0] GANTRY_TIMEOUT_RST = 24'd10000;
	localparam logic [TIMEOUT_W-1:0] DRAWER_TIMEOUT_RST = 24'd10000;
	localparam logic [BACKOFF_W-1:0] BACKOFF_RST        = 16'd200;
	localparam logic [DIST_W-1:0]    CLOSED_DIST_RST    = 16'd40;
	localparam logic [DIST_W-1:0]    OPEN_DIST_RST      = 16'd373;

	typedef enum logic [OP_W-1:0] {
		OP_TICK         = 4'd0,
		OP_UP           = 4'd1,
		OP_DOWN         = 4'd2,
		OP_STOP         = 4'd3,
		OP_HOME         = 4'd4,
		OP_PUMP_ON      = 4'd5,
		OP_PUMP_OFF     = 4'd6,
		OP_DRAWER_OPEN  = 4'd7,
		OP_DRAWER_CLOSE = 4'd8,
		OP_DRAWER_STOP  = 4'd9,
		OP_DRAWER_TOGGLE = 4'd10,
		OP_LIMIT_EDGE   = 4'd11
	} op_t;

	// DIR_A is up for the gantry and opening for the drawer
	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_A   = 2'd1,
		DIR_B   = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_HOMING = 2'd1,
		MODE_UP     = 2'd2,
		MODE_DOWN   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		TEV_NONE   = 2'd0,
		TEV_GANTRY = 2'd1,
		TEV_DRAWER = 2'd2
	} tev_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GANTRY_TIMEOUT = 3'd0,
		REG_DRAWER_TIMEOUT = 3'd1,
		REG_BACKOFF        = 3'd2,
		REG_DRAWER_PRESENT = 3'd3,
		REG_CLOSED_DIST    = 3'd4,
		REG_OPEN_DIST      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic              top;
		logic              bot;
		logic [DIST_W-1:0] dist_mm;
		logic              pour;
	} item_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] gantry_tmo;
		logic [TIMEOUT_W-1:0] drawer_tmo;
		logic [BACKOFF_W-1:0] backoff;
		logic                 present;
		logic [DIST_W-1:0]    closed_dist;
		logic [DIST_W-1:0]    open_dist;
	} cfg_t;

	typedef struct packed {
		mode_t mode_q;
		mode_t mode_n;
		dir_t  dir_q;
		dir_t  dir_n;
		logic  tmo;
	} gantry_stat_t;

	typedef struct packed {
		dir_t dir_q;
		dir_t dir_n;
		logic tmo;
	} drawer_stat_t;

	typedef struct packed {
		logic  pump_on;
		dir_t  gantry_drive;
		dir_t  drawer_drive;
		mode_t gantry_mode_out;
		logic  lockout_flag;
		logic  abort_pour_pulse;
		logic  command_accepted;
		tev_t  timeout_event;
	} result_t;

	function automatic logic gantry_ok(dir_t d, dir_t cur, logic top, logic bot);
		return (d != cur) && !(d == DIR_A && !top) && !(d == DIR_B && !bot);
	endfunction

	function automatic logic drawer_ok(dir_t d, dir_t cur, logic [DIST_W-1:0] dist_mm,
			logic present, logic [DIST_W-1:0] closed_dist, logic [DIST_W-1:0] open_dist);
		return present && (d != cur) && !(d == DIR_A && dist_mm >= open_dist)
			&& !(d == DIR_B && dist_mm <= closed_dist);
	endfunction

endpackage

/* rtl/core/gdmc_cmd_if.sv */
interface gdmc_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [gdmc_pkg::OP_W-1:0]   opcode;
	logic                      top_switch_level;
	logic                      bottom_switch_level;
	logic [gdmc_pkg::DIST_W-1:0] drawer_distance;
	logic                      pour_active;

	modport source (output valid, opcode, top_switch_level, bottom_switch_level,
		drawer_distance, pour_active, input ready);
	modport sink (input valid, opcode, top_switch_level, bottom_switch_level,
		drawer_distance, pour_active, output ready);
endinterface

/* rtl/core/gdmc_res_if.sv */
interface gdmc_res_if;
	logic       valid;
	logic       ready;
	logic       pump_on;
	logic [1:0] gantry_drive;
	logic [1:0] drawer_drive;
	logic [1:0] gantry_mode_out;
	logic       lockout_flag;
	logic       abort_pour_pulse;
	logic       command_accepted;
	logic [1:0] timeout_event;

	modport source (output valid, pump_on, gantry_drive, drawer_drive, gantry_mode_out,
		lockout_flag, abort_pour_pulse, command_accepted, timeout_event, input ready);
	modport sink (input valid, pump_on, gantry_drive, drawer_drive, gantry_mode_out,
		lockout_flag, abort_pour_pulse, command_accepted, timeout_event, output ready);
endinterface

/* rtl/core/gdmc_cfg.sv */
module gdmc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [gdmc_pkg::CFG_IDX_W-1:0]  idx,
	input  logic [gdmc_pkg::CFG_DATA_W-1:0] data,
	output gdmc_pkg::cfg_t                  cfg,
	output logic                            drawer_clr
);

	gdmc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gantry_tmo  <= gdmc_pkg::GANTRY_TIMEOUT_RST;
			cfg_q.drawer_tmo  <= gdmc_pkg::DRAWER_TIMEOUT_RST;
			cfg_q.backoff     <= gdmc_pkg::BACKOFF_RST;
			cfg_q.present     <= 1'b0;
			cfg_q.closed_dist <= gdmc_pkg::CLOSED_DIST_RST;
			cfg_q.open_dist   <= gdmc_pkg::OPEN_DIST_RST;
		end else if (wr_en) begin
			case (gdmc_pkg::reg_idx_t'(idx))
				gdmc_pkg::REG_GANTRY_TIMEOUT: cfg_q.gantry_tmo <= data;
				gdmc_pkg::REG_DRAWER_TIMEOUT: cfg_q.drawer_tmo <= data;
				gdmc_pkg::REG_BACKOFF:        cfg_q.backoff <= data[gdmc_pkg::BACKOFF_W-1:0];
				gdmc_pkg::REG_DRAWER_PRESENT: cfg_q.present <= data[0];
				gdmc_pkg::REG_CLOSED_DIST:    cfg_q.closed_dist <= data[gdmc_pkg::DIST_W-1:0];
				gdmc_pkg::REG_OPEN_DIST:      cfg_q.open_dist <= data[gdmc_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
	// removing the drawer board stops the drawer at once
	assign drawer_clr = wr_en && (gdmc_pkg::reg_idx_t'(idx) == gdmc_pkg::REG_DRAWER_PRESENT)
		&& !data[0];

endmodule

/* rtl/core/gdmc_gantry.sv */
module gdmc_gantry #(
	parameter int TIMER_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  gdmc_pkg::item_t       item,
	input  gdmc_pkg::cfg_t        cfg,
	output gdmc_pkg::gantry_stat_t stat
);

	localparam int CMP_W = (TIMER_BITS > gdmc_pkg::TIMEOUT_W) ? TIMER_BITS : gdmc_pkg::TIMEOUT_W;

	gdmc_pkg::mode_t                mode_q, mode_n;
	gdmc_pkg::dir_t                 dir_q, dir_n, tgt, rev;
	logic [TIMER_BITS-1:0]          timer_q, timer_n;
	logic [gdmc_pkg::BACKOFF_W-1:0] bo_q, bo_n;
	logic                           do_set, tmo;

	always_comb begin
		mode_n  = mode_q;
		dir_n   = dir_q;
		timer_n = timer_q;
		bo_n    = bo_q;
		tmo     = 1'b0;
		tgt     = gdmc_pkg::DIR_OFF;
		rev     = gdmc_pkg::DIR_OFF;
		do_set  = 1'b0;
		if (adv) begin
			case (gdmc_pkg::op_t'(item.opcode))
				gdmc_pkg::OP_TICK: begin
					if (bo_q != '0) begin
						// count down the reversed run, stop at its end
						bo_n = bo_q - 1'b1;
						if (bo_q == gdmc_pkg::BACKOFF_W'(1))
							dir_n = gdmc_pkg::DIR_OFF;
					end else begin
						if (dir_q != gdmc_pkg::DIR_OFF && !(&timer_q))
							timer_n = timer_q + 1'b1;
						if (mode_q == gdmc_pkg::MODE_HOMING || mode_q == gdmc_pkg::MODE_UP) begin
							do_set = 1'b1;
							if (item.top)
								tgt = gdmc_pkg::DIR_A;
							else
								mode_n = gdmc_pkg::MODE_NONE;
						end else if (mode_q == gdmc_pkg::MODE_DOWN) begin
							do_set = 1'b1;
							if (item.bot)
								tgt = gdmc_pkg::DIR_B;
							else
								mode_n = gdmc_pkg::MODE_NONE;
						end
						if (do_set && gdmc_pkg::gantry_ok(tgt, dir_q, item.top, item.bot)) begin
							dir_n = tgt;
							if (tgt != gdmc_pkg::DIR_OFF)
								timer_n = '0;
						end
						if (dir_n != gdmc_pkg::DIR_OFF
								&& CMP_W'(timer_n) > CMP_W'(cfg.gantry_tmo)) begin
							rev = (dir_n == gdmc_pkg::DIR_A) ? gdmc_pkg::DIR_B : gdmc_pkg::DIR_A;
							if (gdmc_pkg::gantry_ok(rev, dir_n, item.top, item.bot)) begin
								dir_n   = rev;
								timer_n = '0;
							end
							if (cfg.backoff == '0)
								dir_n = gdmc_pkg::DIR_OFF;
							else
								bo_n = cfg.backoff;
							mode_n = gdmc_pkg::MODE_NONE;
							tmo    = 1'b1;
						end
					end
				end
				gdmc_pkg::OP_UP, gdmc_pkg::OP_DOWN, gdmc_pkg::OP_STOP: begin
					case (gdmc_pkg::op_t'(item.opcode))
						gdmc_pkg::OP_UP:   tgt = gdmc_pkg::DIR_A;
						gdmc_pkg::OP_DOWN: tgt = gdmc_pkg::DIR_B;
						default:           tgt = gdmc_pkg::DIR_OFF;
					endcase
					if (!item.pour
							&& !(mode_q == gdmc_pkg::MODE_UP && tgt == gdmc_pkg::DIR_A)
							&& !(mode_q == gdmc_pkg::MODE_DOWN && tgt == gdmc_pkg::DIR_B)) begin
						case (tgt)
							gdmc_pkg::DIR_A: mode_n = gdmc_pkg::MODE_UP;
							gdmc_pkg::DIR_B: mode_n = gdmc_pkg::MODE_DOWN;
							default:         mode_n = gdmc_pkg::MODE_NONE;
						endcase
						do_set = 1'b1;
					end
				end
				gdmc_pkg::OP_HOME: begin
					if (!item.pour && mode_q != gdmc_pkg::MODE_HOMING) begin
						tgt    = gdmc_pkg::DIR_A;
						mode_n = gdmc_pkg::MODE_HOMING;
						do_set = 1'b1;
					end
				end
				gdmc_pkg::OP_LIMIT_EDGE: begin
					do_set = 1'b1;
				end
				default: ;
			endcase
			if (gdmc_pkg::op_t'(item.opcode) != gdmc_pkg::OP_TICK && do_set
					&& gdmc_pkg::gantry_ok(tgt, dir_q, item.top, item.bot)) begin
				dir_n = tgt;
				if (tgt != gdmc_pkg::DIR_OFF)
					timer_n = '0;
				bo_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= gdmc_pkg::MODE_NONE;
			dir_q   <= gdmc_pkg::DIR_OFF;
			timer_q <= '0;
			bo_q    <= '0;
		end else begin
			mode_q  <= mode_n;
			dir_q   <= dir_n;
			timer_q <= timer_n;
			bo_q    <= bo_n;
		end
	end

	assign stat.mode_q = mode_q;
	assign stat.mode_n = mode_n;
	assign stat.dir_q  = dir_q;
	assign stat.dir_n  = dir_n;
	assign stat.tmo    = tmo;

endmodule

/* rtl/core/gdmc_drawer.sv */
module gdmc_drawer #(
	parameter int TIMER_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   clr,
	input  gdmc_pkg::item_t        item,
	input  gdmc_pkg::cfg_t         cfg,
	output gdmc_pkg::drawer_stat_t stat
);

	localparam int CMP_W = (TIMER_BITS > gdmc_pkg::TIMEOUT_W) ? TIMER_BITS : gdmc_pkg::TIMEOUT_W;

	gdmc_pkg::dir_t                 dir_q, dir_n, tgt, rev;
	logic [TIMER_BITS-1:0]          timer_q, timer_n;
	logic [gdmc_pkg::BACKOFF_W-1:0] bo_q, bo_n;
	logic [gdmc_pkg::DIST_W:0]      dist_sum;
	logic                           do_set, tmo;

	assign dist_sum = {1'b0, cfg.closed_dist} + {1'b0, cfg.open_dist};

	always_comb begin
		dir_n   = dir_q;
		timer_n = timer_q;
		bo_n    = bo_q;
		tmo     = 1'b0;
		tgt     = gdmc_pkg::DIR_OFF;
		rev     = gdmc_pkg::DIR_OFF;
		do_set  = 1'b0;
		if (clr) begin
			dir_n   = gdmc_pkg::DIR_OFF;
			timer_n = '0;
			bo_n    = '0;
		end else if (adv) begin
			case (gdmc_pkg::op_t'(item.opcode))
				gdmc_pkg::OP_TICK: begin
					if (bo_q != '0) begin
						bo_n = bo_q - 1'b1;
						if (bo_q == gdmc_pkg::BACKOFF_W'(1))
							dir_n = gdmc_pkg::DIR_OFF;
					end else begin
						if (dir_q != gdmc_pkg::DIR_OFF && !(&timer_q))
							timer_n = timer_q + 1'b1;
						// stop at the end position
						if ((dir_q == gdmc_pkg::DIR_A && item.dist_mm >= cfg.open_dist)
								|| (dir_q == gdmc_pkg::DIR_B
								&& item.dist_mm <= cfg.closed_dist)) begin
							if (cfg.present)
								dir_n = gdmc_pkg::DIR_OFF;
						end
						if (dir_n != gdmc_pkg::DIR_OFF
								&& CMP_W'(timer_n) > CMP_W'(cfg.drawer_tmo)) begin
							rev = (dir_n == gdmc_pkg::DIR_A) ? gdmc_pkg::DIR_B : gdmc_pkg::DIR_A;
							if (gdmc_pkg::drawer_ok(rev, dir_n, item.dist_mm, cfg.present,
									cfg.closed_dist, cfg.open_dist)) begin
								dir_n   = rev;
								timer_n = '0;
							end
							if (cfg.backoff == '0)
								dir_n = gdmc_pkg::DIR_OFF;
							else
								bo_n = cfg.backoff;
							tmo = 1'b1;
						end
					end
				end
				gdmc_pkg::OP_DRAWER_OPEN: begin
					tgt    = gdmc_pkg::DIR_A;
					do_set = 1'b1;
				end
				gdmc_pkg::OP_DRAWER_CLOSE: begin
					tgt    = gdmc_pkg::DIR_B;
					do_set = 1'b1;
				end
				gdmc_pkg::OP_DRAWER_STOP: begin
					do_set = 1'b1;
				end
				gdmc_pkg::OP_DRAWER_TOGGLE: begin
					// close from the far half, open from the near half
					tgt    = (item.dist_mm >= dist_sum[gdmc_pkg::DIST_W:1]) ? gdmc_pkg::DIR_B
						: gdmc_pkg::DIR_A;
					do_set = 1'b1;
				end
				default: ;
			endcase
			if (do_set && gdmc_pkg::drawer_ok(tgt, dir_q, item.dist_mm, cfg.present,
					cfg.closed_dist, cfg.open_dist)) begin
				dir_n = tgt;
				if (tgt != gdmc_pkg::DIR_OFF)
					timer_n = '0;
				bo_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= gdmc_pkg::DIR_OFF;
			timer_q <= '0;
			bo_q    <= '0;
		end else begin
			dir_q   <= dir_n;
			timer_q <= timer_n;
			bo_q    <= bo_n;
		end
	end

	assign stat.dir_q = dir_q;
	assign stat.dir_n = dir_n;
	assign stat.tmo   = tmo;

endmodule

/* rtl/core/gantry_drawer_motor_controller.sv */
// An item taken on cmd goes into the input register, and its result is then offered on res
// from the result register. Throughput: one item per cycle while res accepts results; the single
// pass of next-state logic between the input register and the result register sets that figure.
// Reset: arst_n (asynchronous, active low) stops all motors, clears modes, timers,
// backoff and lockout, empties both registers and loads the register defaults.
module gantry_drawer_motor_controller #(
	parameter int TIMER_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gdmc_cmd_if.sink                        cmd,
	gdmc_res_if.source                      res,
	input  logic                            cfg_wr_en,
	input  logic [gdmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gdmc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// input register
	gdmc_pkg::item_t item_s1;
	logic            valid_s1;

	// result register
	gdmc_pkg::result_t res_q;
	logic              res_valid_q;

	// pump and lockout state
	logic pump_q, pump_n;
	logic lockout_q, lockout_n;

	logic                   adv, is_tick, is_cmd;
	gdmc_pkg::cfg_t         cfg;
	logic                   drawer_clr;
	gdmc_pkg::gantry_stat_t gstat;
	gdmc_pkg::drawer_stat_t dstat;
	gdmc_pkg::result_t      res_n;

	// Move the item in the input register forward whenever the result register is
	// empty or is being drained this cycle; take a new item whenever the input
	// register is empty or moving forward.
	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd.valid && cmd.ready)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.opcode  <= cmd.opcode;
			item_s1.top     <= cmd.top_switch_level;
			item_s1.bot     <= cmd.bottom_switch_level;
			item_s1.dist_mm <= cmd.drawer_distance;
			item_s1.pour    <= cmd.pour_active;
		end
	end

	gdmc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_wr_en),
		.idx        (cfg_index),
		.data       (cfg_data),
		.cfg        (cfg),
		.drawer_clr (drawer_clr)
	);

	gdmc_gantry #(.TIMER_BITS(TIMER_BITS)) u_gantry (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.stat   (gstat)
	);

	gdmc_drawer #(.TIMER_BITS(TIMER_BITS)) u_drawer (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.clr    (drawer_clr),
		.item   (item_s1),
		.cfg    (cfg),
		.stat   (dstat)
	);

	assign is_tick = (gdmc_pkg::op_t'(item_s1.opcode) == gdmc_pkg::OP_TICK);
	// only the motor, pump and mode commands report acceptance
	assign is_cmd  = item_s1.opcode inside {[gdmc_pkg::OP_UP:gdmc_pkg::OP_DRAWER_TOGGLE]};

	always_comb begin
		pump_n    = pump_q;
		lockout_n = lockout_q;
		if (adv) begin
			case (gdmc_pkg::op_t'(item_s1.opcode))
				gdmc_pkg::OP_PUMP_ON:  pump_n = 1'b1;
				gdmc_pkg::OP_PUMP_OFF: pump_n = 1'b0;
				default: ;
			endcase
			// a gantry timeout latches the lockout until reset
			if (is_tick && gstat.tmo)
				lockout_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_q    <= 1'b0;
			lockout_q <= 1'b0;
		end else begin
			pump_q    <= pump_n;
			lockout_q <= lockout_n;
		end
	end

	// assemble the result from the state that this item leaves behind
	always_comb begin
		res_n.pump_on          = pump_n;
		res_n.gantry_drive     = gstat.dir_n;
		res_n.drawer_drive     = dstat.dir_n;
		res_n.gantry_mode_out  = gstat.mode_n;
		res_n.lockout_flag     = lockout_n;
		res_n.abort_pour_pulse = is_tick && gstat.tmo && item_s1.pour;
		res_n.command_accepted = is_cmd && ((gstat.mode_n != gstat.mode_q)
			|| (gstat.dir_n != gstat.dir_q) || (dstat.dir_n != dstat.dir_q)
			|| (pump_n != pump_q));
		// the gantry wins when both motors time out on one tick
		if (is_tick && gstat.tmo)
			res_n.timeout_event = gdmc_pkg::TEV_GANTRY;
		else if (is_tick && dstat.tmo)
			res_n.timeout_event = gdmc_pkg::TEV_DRAWER;
		else
			res_n.timeout_event = gdmc_pkg::TEV_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_n;
	end

	assign res.valid            = res_valid_q;
	assign res.pump_on          = res_q.pump_on;
	assign res.gantry_drive     = res_q.gantry_drive;
	assign res.drawer_drive     = res_q.drawer_drive;
	assign res.gantry_mode_out  = res_q.gantry_mode_out;
	assign res.lockout_flag     = res_q.lockout_flag;
	assign res.abort_pour_pulse = res_q.abort_pour_pulse;
	assign res.command_accepted = res_q.command_accepted;
	assign res.timeout_event    = res_q.timeout_event;

	// lockout never clears without reset
	a_lockout_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		lockout_q |=> lockout_q)
		else $error("lockout cleared without reset");

	// an abort request only comes with a gantry timeout
	a_abort_with_tmo: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.abort_pour_pulse) |->
			(res_q.timeout_event == gdmc_pkg::TEV_GANTRY))
		else $error("abort pulse without gantry timeout");

	// a gantry timeout result always shows the lockout set
	a_tmo_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.timeout_event == gdmc_pkg::TEV_GANTRY) |-> res_q.lockout_flag)
		else $error("gantry timeout without lockout");

	// the input side stalls only when both registers hold an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && res_valid_q && !res.ready))
		else $error("input stalled with room to advance");

endmodule
